// File: rtl/poisson_haar_coefficient_threshold_macros.svh
// Assertion macros for the Poisson Haar coefficient threshold block.
// Included by the top level; the macros expect clk and rst in scope.
`ifndef POISSON_HAAR_COEFFICIENT_THRESHOLD_MACROS_SVH
`define POISSON_HAAR_COEFFICIENT_THRESHOLD_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define PHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pht check failed");
// Check that cons holds in the cycle after ante.
`define PHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pht check failed");
`else
`define PHT_ASSERT_NOW(lbl, ante, cons)
`define PHT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/pht_pkg.sv
// Shared constants and codes for the Poisson Haar coefficient threshold block.
// No dependencies.
package pht_pkg;
  localparam int COEF_WIDTH_DEF  = 32;
  localparam int SCALE_COUNT_DEF = 16;
  localparam int SCALE_W         = 4;
  localparam int SAMPLE_W        = 32;
  localparam int LEVEL_W         = 32;
  localparam int RAD_W           = 64;
  localparam int ROOT_W          = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BG_SOURCE  = 3'd0,
    REG_FLAT_BG    = 3'd1,
    REG_Z          = 3'd2,
    REG_FIRST_SCL  = 3'd3,
    REG_POS_ONLY   = 3'd4,
    REG_SOFT       = 3'd5
  } reg_idx_t;

  localparam logic [1:0] BG_FLAT   = 2'd0;
  localparam logic [1:0] BG_LOWRES = 2'd1;
  localparam logic [15:0] Z_RESET  = 16'd768;
endpackage

// File: rtl/pht_in_if.sv
// Input item channel: coefficient, background sample and scale.
// Depends on pht_pkg.
interface pht_in_if #(parameter int COEF_WIDTH = pht_pkg::COEF_WIDTH_DEF);
  import pht_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COEF_WIDTH-1:0]  coefficient;
  logic [SAMPLE_W-1:0]           background_sample;
  logic [SCALE_W-1:0]            scale;
  modport source (output valid, coefficient, background_sample, scale, input ready);
  modport sink   (input valid, coefficient, background_sample, scale, output ready);
endinterface

// File: rtl/pht_out_if.sv
// Result item channel: filtered coefficient and detection flag.
// Depends on pht_pkg.
interface pht_out_if #(parameter int COEF_WIDTH = pht_pkg::COEF_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [COEF_WIDTH-1:0]  filtered_coefficient;
  logic                          detected;
  modport source (output valid, filtered_coefficient, detected, input ready);
  modport sink   (input valid, filtered_coefficient, detected, output ready);
endinterface

// File: rtl/pht_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on pht_pkg.
interface pht_cfg_if;
  import pht_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pht_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side payload.
// Depends on pht_pkg; stage valid bits are kept by the caller.
module pht_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic [pht_pkg::ROOT_W-1:0]    ld,
  input  logic [pht_pkg::RAD_W-1:0]     rad,
  input  logic [SIDE_W-1:0]             side_in,
  output logic [pht_pkg::ROOT_W-1:0]    root,
  output logic [SIDE_W-1:0]             side_out
);
  import pht_pkg::*;
  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  x_q    [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0]  x_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [SIDE_W-1:0] side_i;
    logic [REM_W-1:0]  r2;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign x_i    = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign x_i    = x_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign side_i = side_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign r2    = {rem_i[REM_W-3:0], x_i[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign take  = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        x_q[k]    <= {x_i[RAD_W-3:0], 2'b00};
        rem_q[k]  <= take ? (r2 - trial) : r2;
        root_q[k] <= {root_i[ROOT_W-2:0], take};
        side_q[k] <= side_i;
      end
    end
  end

  assign root     = root_q[ROOT_W-1];
  assign side_out = side_q[ROOT_W-1];
endmodule

// File: rtl/poisson_haar_coefficient_threshold.sv
// Poisson Haar coefficient threshold: top level with config registers and pipeline.
// Depends on pht_pkg, pht_in_if, pht_out_if, pht_cfg_if, pht_sqrt and the macro header.
//
// Takes one Haar detail coefficient (signed Q15.16) with its scale and a
// background sample per item, and returns the thresholded coefficient and a
// detection flag. The threshold is z^2/2^(s+2) + sqrt(z^4/4^(s+2) + lambda*z^2)
// with lambda flat, a low-resolution sample scaled by 2^-(s+1), or a model
// sample, saturating at the top of Q16.16. One item enters per clock while
// src.ready is high; the pipe has 37 register stages, the first loaded at
// the edge that accepts the item: three front stages (background select
// and z^2, the two 32x32 products, the radicand sum), 32 square-root stages
// that settle one root bit each, one stage forming the level, and the
// output register. Each stage moves on its own when the stage after it is
// empty or moving, so bubbles close up under a stalled output and src keeps
// accepting items until the pipe is full.
// Configuration writes are always taken; soft_mode is read at the last stage
// and the other registers at the first, so write them only with the pipe empty.
module poisson_haar_coefficient_threshold #(
  parameter int COEF_WIDTH  = pht_pkg::COEF_WIDTH_DEF,
  parameter int SCALE_COUNT = pht_pkg::SCALE_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  pht_cfg_if.sink  cfg,
  pht_in_if.sink   src,
  pht_out_if.source dst
);
  import pht_pkg::*;

  localparam int NST   = 3 + ROOT_W + 2;
  localparam int SQ0   = 3;
  localparam int LEVST = NST - 2;
  localparam int OUTST = NST - 1;
  localparam int WW    = ((COEF_WIDTH > LEVEL_W) ? COEF_WIDTH : LEVEL_W) + 2;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] c;
    logic [LEVEL_W-1:0]           zsh;
    logic                         kill;
  } side_t;

  // ---------------- configuration registers ----------------
  logic [1:0]          background_source;
  logic [SAMPLE_W-1:0] flat_background;
  logic [15:0]         threshold_z;
  logic [SCALE_W-1:0]  first_scale;
  logic                keep_positive_only;
  logic                soft_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_source  <= BG_FLAT;
      flat_background    <= '0;
      threshold_z        <= Z_RESET;
      first_scale        <= '0;
      keep_positive_only <= 1'b0;
      soft_mode          <= 1'b0;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_BG_SOURCE: background_source  <= cfg.data[1:0];
        REG_FLAT_BG:   flat_background    <= cfg.data[SAMPLE_W-1:0];
        REG_Z:         threshold_z        <= cfg.data[15:0];
        REG_FIRST_SCL: first_scale        <= cfg.data[SCALE_W-1:0];
        REG_POS_ONLY:  keep_positive_only <= cfg.data[0];
        REG_SOFT:      soft_mode          <= cfg.data[0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------- stage flow control ----------------
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = dst.ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign src.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= src.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------- stage 0: clamp scale, pick lambda, square z ----------------
  logic [SCALE_W-1:0]  s_in;
  logic [SAMPLE_W-1:0] lam_in;
  logic signed [COEF_WIDTH-1:0] c0;
  logic [LEVEL_W-1:0]  z2_0;
  logic [SAMPLE_W-1:0] lam0;
  logic [SCALE_W-1:0]  s0;
  logic                kill0;

  always_comb begin
    s_in = (src.scale > SCALE_W'(SCALE_COUNT - 1)) ? SCALE_W'(SCALE_COUNT - 1) : src.scale;
    case (background_source)
      BG_FLAT:   lam_in = flat_background;
      BG_LOWRES: lam_in = src.background_sample >> ({1'b0, s_in} + 5'd1);
      default:   lam_in = src.background_sample;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c0    <= src.coefficient;
      z2_0  <= LEVEL_W'(threshold_z) * LEVEL_W'(threshold_z);
      lam0  <= lam_in;
      s0    <= s_in;
      // early scale, or negative with positive-only set, gives zero
      kill0 <= (s_in < first_scale) || (keep_positive_only && src.coefficient[COEF_WIDTH-1]);
    end
  end

  // ---------------- stage 1: z^4 and lambda*z^2 ----------------
  logic signed [COEF_WIDTH-1:0] c1;
  logic                kill1;
  logic [SCALE_W-1:0]  s1;
  logic [RAD_W-1:0]    quad1;
  logic [RAD_W-1:0]    prod1;
  logic [LEVEL_W-1:0]  zsh1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      c1    <= c0;
      kill1 <= kill0;
      s1    <= s0;
      quad1 <= RAD_W'(z2_0) * RAD_W'(z2_0);
      prod1 <= RAD_W'(lam0) * RAD_W'(z2_0);
      zsh1  <= z2_0 >> ({1'b0, s0} + 5'd2);
    end
  end

  // ---------------- stage 2: radicand, saturated ----------------
  logic [RAD_W:0]     rad_sum;
  logic [RAD_W-1:0]   rad2;
  side_t              side2;

  assign rad_sum = {1'b0, quad1 >> ({2'b00, s1} * 6'd2 + 6'd4)} + {1'b0, prod1};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      rad2  <= rad_sum[RAD_W] ? {RAD_W{1'b1}} : rad_sum[RAD_W-1:0];
      side2 <= '{c: c1, zsh: zsh1, kill: kill1};
    end
  end

  // ---------------- square root stages ----------------
  logic [ROOT_W-1:0] root_sq;
  side_t             side_sq;

  pht_sqrt #(.SIDE_W($bits(side_t))) u_sqrt (
    .clk      (clk),
    .ld       (rdy[SQ0 +: ROOT_W]),
    .rad      (rad2),
    .side_in  (side2),
    .root     (root_sq),
    .side_out (side_sq)
  );

  // ---------------- level stage ----------------
  logic [LEVEL_W:0]   lev_sum;
  logic [LEVEL_W-1:0] lev_q;
  logic signed [COEF_WIDTH-1:0] c_lev;
  logic               kill_lev;

  assign lev_sum = {1'b0, side_sq.zsh} + {1'b0, root_sq};

  always_ff @(posedge clk) begin
    if (rdy[LEVST]) begin
      lev_q    <= lev_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : lev_sum[LEVEL_W-1:0];
      c_lev    <= side_sq.c;
      kill_lev <= side_sq.kill;
    end
  end

  // ---------------- threshold and output register ----------------
  logic signed [WW-1:0] ce;
  logic signed [WW-1:0] le;
  logic signed [WW-1:0] res;

  always_comb begin
    ce = {{(WW-COEF_WIDTH){c_lev[COEF_WIDTH-1]}}, c_lev};
    le = {{(WW-LEVEL_W){1'b0}}, lev_q};
    if (kill_lev) begin
      res = '0;
    end else if (!soft_mode) begin
      res = (ce >= le || ce <= -le) ? ce : '0;
    end else if (ce > 0) begin
      res = (ce > le) ? ce - le : '0;
    end else begin
      res = (ce < -le) ? ce + le : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[OUTST]) begin
      dst.filtered_coefficient <= res[COEF_WIDTH-1:0];
      dst.detected             <= (res != '0);
    end
  end

  assign dst.valid = v[OUTST];

  // ---------------- checks ----------------
  `include "poisson_haar_coefficient_threshold_macros.svh"

  `PHT_ASSERT_NOW(a_det_matches, dst.valid, dst.detected == (dst.filtered_coefficient != '0))
  `PHT_ASSERT_NEXT(a_accept_fills, src.valid && src.ready, v[0])
  `PHT_ASSERT_NEXT(a_drain_empties, dst.valid && dst.ready && !v[LEVST], !dst.valid)
endmodule
